/* hw/rtl/tql_pkg.sv */
// Shared types, constants and helpers for the tabular Q-learning engine.
package tql_pkg;

  localparam int TQL_GRID  = 64;
  localparam int TQL_KINDS = 2;
  localparam int TQL_MOVES = 3;

  localparam int TQL_QW     = 20;
  localparam int TQL_RATE_W = 16;
  localparam int TQL_REW_W  = 10;
  localparam int TQL_POS_W  = 6;
  localparam int TQL_MOVE_W = 2;

  localparam int TQL_IN_W   = 72;
  localparam int TQL_USER_W = 2;
  localparam int TQL_OUT_W  = 24;

  localparam int IN_KIND_LO  = 0;
  localparam int IN_PX_LO    = 1;
  localparam int IN_BY_LO    = 7;
  localparam int IN_BX_LO    = 13;
  localparam int IN_MOVE_LO  = 19;
  localparam int IN_OPV_LO   = 21;
  localparam int IN_REW_LO   = 41;
  localparam int IN_NKIND_LO = 51;
  localparam int IN_NPX_LO   = 52;
  localparam int IN_NBY_LO   = 58;
  localparam int IN_NBX_LO   = 64;

  localparam int OUT_MOVE_LO   = 0;
  localparam int OUT_GREEDY_LO = 2;
  localparam int OUT_VAL_LO    = 3;
  localparam int OUT_SAT_LO    = 23;

  localparam int TQL_CFG_IW = 3;
  localparam logic [TQL_CFG_IW-1:0] CFG_LEARN_RATE = 3'd0;
  localparam logic [TQL_CFG_IW-1:0] CFG_DISCOUNT   = 3'd1;
  localparam logic [TQL_CFG_IW-1:0] CFG_EXPLORE    = 3'd2;
  localparam logic [TQL_CFG_IW-1:0] CFG_HIT_VALUE  = 3'd3;
  localparam logic [TQL_CFG_IW-1:0] CFG_DIE_VALUE  = 3'd4;

  localparam logic [TQL_RATE_W-1:0] RST_LEARN_RATE = 16'd6554;
  localparam logic [TQL_RATE_W-1:0] RST_DISCOUNT   = 16'd62259;
  localparam logic [TQL_RATE_W-1:0] RST_EXPLORE    = 16'd65535;
  localparam logic signed [TQL_REW_W-1:0] RST_HIT_VALUE = 10'sd1;
  localparam logic signed [TQL_REW_W-1:0] RST_DIE_VALUE = -10'sd1;

  localparam logic [TQL_MOVE_W-1:0] MOVE_LAST = 2'd2;

  // learn arithmetic widths
  localparam int P1W = 37;
  localparam int P2W = 37;
  localparam int IW  = 38;
  localparam int P3W = 54;
  localparam int TW  = 56;
  localparam int QFW = TW - 32;
  localparam logic signed [TW-1:0]  RND_HALF = 56'sd2147483648;
  localparam logic signed [QFW-1:0] Q_HI = 24'sd524287;
  localparam logic signed [QFW-1:0] Q_LO = -24'sd524288;
  localparam logic [TQL_QW-1:0] Q_HI_BITS = 20'h7FFFF;
  localparam logic [TQL_QW-1:0] Q_LO_BITS = 20'h80000;
  localparam logic [TQL_RATE_W:0] FRAC_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ACT_CHOOSE = 2'd0,
    ACT_LEARN  = 2'd1,
    ACT_LOAD   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ISSUE,
    ST_FIRST,
    ST_CUR,
    ST_SUM,
    ST_MUL2,
    ST_DONE
  } state_t;

  typedef logic [TQL_MOVES-1:0][TQL_QW-1:0] q_row_t;

  function automatic logic [TQL_MOVE_W-1:0] best_move(input q_row_t r);
    logic [TQL_MOVE_W-1:0] b;
    b = '0;
    for (int i = 1; i < TQL_MOVES; i++) begin
      if ($signed(r[b]) < $signed(r[i])) b = TQL_MOVE_W'(i);
    end
    return b;
  endfunction

endpackage

/* hw/rtl/tql_qmem.sv */
// Q table storage: one row of move values per situation, registered read.
module tql_qmem
  import tql_pkg::*;
#(
  parameter int DEPTH = TQL_KINDS * TQL_GRID * TQL_GRID * TQL_GRID,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output q_row_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  q_row_t        wr_data
);

  q_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/tabular_q_learning_engine.sv */
// Top level: Q-table engine with epsilon-greedy choice, learn and load items.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: situation, move, operands; tuser: action
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: chosen move, greedy, value, saturated
//  cfg       in   cfg_wr_en                       cfg_index, cfg_data
//
// One item at a time. Choose, load and no-op items pass ST_ADDR, ST_ISSUE, ST_FIRST and ST_DONE;
// learn also passes ST_CUR, ST_SUM and ST_MUL2: two table reads serialised on the single read
// port, then two dependent multiplies and the rounding add before the write-back.
// Reset idles the controller, clears output valid and loads config defaults; table is not cleared.
// A result waiting on m_axis does not block the next input transfer; the following
// result holds in the final stage until the output register is free.
module tabular_q_learning_engine
  import tql_pkg::*;
#(
  parameter int GRID  = TQL_GRID,
  parameter int KINDS = TQL_KINDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ball_kind, paddle_x, ball_y, ball_x, move, operand_value, reward,
  // next_ball_kind, next_paddle_x, next_ball_y, next_ball_x, zero pad
  input  logic [TQL_IN_W-1:0]   s_axis_tdata,
  // action
  input  logic [TQL_USER_W-1:0] s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // chosen_move, was_greedy, result_value, saturated
  output logic [TQL_OUT_W-1:0]  m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [TQL_CFG_IW-1:0] cfg_index,
  input  logic [TQL_RATE_W-1:0] cfg_data
);

  localparam int CW    = $clog2(GRID);
  localparam int KW    = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int DEPTH = KINDS * GRID * GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [7:0]    GRID_C = 8'(GRID);
  localparam logic [AW-1:0] GRID_A = AW'(GRID);

  function automatic logic [CW-1:0] coord_mod(input logic [TQL_POS_W-1:0] v);
    logic [7:0] r;
    r = 8'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= GRID_C) r = r - GRID_C;
    end
    return r[CW-1:0];
  endfunction

  function automatic logic [KW-1:0] kind_mod(input logic k);
    return (KINDS > 1) ? KW'(k) : '0;
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic k, input logic [TQL_POS_W-1:0] p,
                                               input logic [TQL_POS_W-1:0] y,
                                               input logic [TQL_POS_W-1:0] x);
    return ((AW'(kind_mod(k)) * GRID_A + AW'(coord_mod(p))) * GRID_A
            + AW'(coord_mod(y))) * GRID_A + AW'(coord_mod(x));
  endfunction

  // configuration registers
  logic [TQL_RATE_W-1:0]       learn_rate;
  logic [TQL_RATE_W-1:0]       discount_factor;
  logic [TQL_RATE_W-1:0]       explore_threshold;
  logic signed [TQL_REW_W-1:0] hit_value;
  logic signed [TQL_REW_W-1:0] die_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate        <= RST_LEARN_RATE;
      discount_factor   <= RST_DISCOUNT;
      explore_threshold <= RST_EXPLORE;
      hit_value         <= RST_HIT_VALUE;
      die_value         <= RST_DIE_VALUE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEARN_RATE: learn_rate        <= cfg_data;
        CFG_DISCOUNT:   discount_factor   <= cfg_data;
        CFG_EXPLORE:    explore_threshold <= cfg_data;
        CFG_HIT_VALUE:  hit_value         <= cfg_data[TQL_REW_W-1:0];
        CFG_DIE_VALUE:  die_value         <= cfg_data[TQL_REW_W-1:0];
        default: ;
      endcase
    end
  end

  // held item
  action_t                      act;
  logic                         kind, nkind;
  logic [TQL_POS_W-1:0]         px, by, bx, npx, nby, nbx;
  logic [TQL_MOVE_W-1:0]        mv;
  logic signed [TQL_QW-1:0]     opv;
  logic signed [TQL_REW_W-1:0]  rew;

  logic [AW-1:0]                cur_addr, nxt_addr;
  logic signed [TQL_QW-1:0]     mx;
  logic signed [P1W-1:0]        p1;
  logic signed [P2W-1:0]        p2;
  logic signed [IW-1:0]         inner;
  logic signed [P3W-1:0]        p3;

  state_t state, state_next;
  logic   accept;
  logic   rd_en, wr_en, out_load;
  logic [AW-1:0] rd_addr;
  q_row_t rd_data, wr_row;

  logic [TQL_MOVE_W-1:0] in_move;
  logic signed [TQL_QW-1:0] old_q;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_move       = s_axis_tdata[IN_MOVE_LO +: TQL_MOVE_W];
  assign old_q         = $signed(rd_data[mv]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = cur_addr;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_ISSUE;
      ST_ISSUE: begin
        rd_en      = 1'b1;
        rd_addr    = (act == ACT_LEARN) ? nxt_addr : cur_addr;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (act == ACT_LEARN) begin
          rd_en      = 1'b1;
          state_next = ST_CUR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CUR:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          wr_en      = (act == ACT_LEARN) || (act == ACT_LOAD);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action_t'(s_axis_tuser);
      kind  <= s_axis_tdata[IN_KIND_LO];
      px    <= s_axis_tdata[IN_PX_LO +: TQL_POS_W];
      by    <= s_axis_tdata[IN_BY_LO +: TQL_POS_W];
      bx    <= s_axis_tdata[IN_BX_LO +: TQL_POS_W];
      mv    <= (in_move > MOVE_LAST) ? MOVE_LAST : in_move;
      opv   <= s_axis_tdata[IN_OPV_LO +: TQL_QW];
      rew   <= s_axis_tdata[IN_REW_LO +: TQL_REW_W];
      nkind <= s_axis_tdata[IN_NKIND_LO];
      npx   <= s_axis_tdata[IN_NPX_LO +: TQL_POS_W];
      nby   <= s_axis_tdata[IN_NBY_LO +: TQL_POS_W];
      nbx   <= s_axis_tdata[IN_NBX_LO +: TQL_POS_W];
    end
    if (state == ST_ADDR) begin
      cur_addr <= entry_addr(kind, px, by, bx);
      nxt_addr <= entry_addr(nkind, npx, nby, nbx);
    end
    if (state == ST_FIRST) begin
      mx <= $signed(rd_data[best_move(rd_data)]);
    end
    if (state == ST_CUR) begin
      p1 <= P1W'($signed({1'b0, discount_factor})) * P1W'(mx);
      p2 <= P2W'($signed({1'b0, FRAC_ONE - {1'b0, learn_rate}})) * P2W'(old_q);
    end
    if (state == ST_SUM) begin
      inner <= (IW'(rew) <<< 26) + IW'(p1);
    end
    if (state == ST_MUL2) begin
      p3 <= P3W'($signed({1'b0, learn_rate})) * P3W'(inner);
    end
  end

  // final stage: result and write-back row
  logic signed [TW-1:0]     total;
  logic signed [QFW-1:0]    q_full;
  logic [TQL_QW-1:0]        res_val;
  logic                     res_sat, res_greedy;
  logic [TQL_MOVE_W-1:0]    res_move;

  always_comb begin
    total      = (TW'(p2) <<< 16) + TW'(p3) + RND_HALF;
    q_full     = total[TW-1:32];
    res_val    = '0;
    res_sat    = 1'b0;
    res_greedy = 1'b0;
    res_move   = '0;
    case (act)
      ACT_CHOOSE: begin
        res_greedy = (opv > $signed({4'b0000, explore_threshold}));
        res_move   = res_greedy ? best_move(rd_data) : mv;
      end
      ACT_LEARN: begin
        if ((rew == hit_value) || (rew == die_value)) begin
          res_val = {rew, 10'b0};
        end else if (q_full > Q_HI) begin
          res_val = Q_HI_BITS;
          res_sat = 1'b1;
        end else if (q_full < Q_LO) begin
          res_val = Q_LO_BITS;
          res_sat = 1'b1;
        end else begin
          res_val = q_full[TQL_QW-1:0];
        end
      end
      ACT_LOAD: res_val = opv;
      default: ;
    endcase
    wr_row     = rd_data;
    wr_row[mv] = res_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {res_sat, res_val, res_greedy, res_move};
    end
  end

  tql_qmem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_qmem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (cur_addr),
    .wr_data (wr_row)
  );

endmodule

/* hw/rtl/tql_checker.sv */
// Port-level checks for the Q-learning engine, bound to the top level.
module tql_checker
  import tql_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TQL_OUT_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rst_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in progress");

  a_greedy_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_GREEDY_LO]
      |-> m_axis_tdata[OUT_VAL_LO +: TQL_QW] == '0 && !m_axis_tdata[OUT_SAT_LO])
    else $error("greedy choice carries a value");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_SAT_LO]
      |-> m_axis_tdata[OUT_VAL_LO +: TQL_QW] == Q_HI_BITS
       || m_axis_tdata[OUT_VAL_LO +: TQL_QW] == Q_LO_BITS)
    else $error("saturated value not at a limit");

endmodule

bind tabular_q_learning_engine tql_checker u_tql_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the tabular Q-learning engine with its own Q-table predictor.
module testbench;
  import tql_pkg::*;

  localparam int SIT_W = 1 + 3 * TQL_POS_W;
  localparam int SETTLE = 10;
  localparam longint Q_TOP = 524287;
  localparam longint Q_BOT = -524288;
  localparam logic [SIT_W-1:0] SIT_A = '0;
  localparam logic [SIT_W-1:0] SIT_B = '1;
  localparam logic [SIT_W-1:0] SIT_C = 19'h2AAAA;
  localparam logic [TQL_MOVE_W-1:0] SLOT0 = 2'd0;
  localparam logic [TQL_MOVE_W-1:0] SLOT1 = 2'd1;
  localparam logic [TQL_MOVE_W-1:0] SLOT_ALIAS = 2'd3;
  localparam logic [TQL_REW_W-1:0] REW_TOP = 10'h1FF;
  localparam logic [TQL_REW_W-1:0] REW_BOT = 10'h200;

  typedef enum logic [1:0] {EV_ITEM, EV_CFG, EV_DRAIN} ev_kind_t;

  typedef struct {
    ev_kind_t                kind;
    action_t                 act;
    logic [TQL_IN_W-1:0]     data;
    logic [TQL_CFG_IW-1:0]   reg_idx;
    logic [TQL_RATE_W-1:0]   reg_val;
  } stim_t;

  typedef struct {
    action_t                 act;
    logic [SIT_W-1:0]        sit;
    logic [TQL_MOVE_W-1:0]   mv;
    logic [TQL_QW-1:0]       opv;
    logic [TQL_REW_W-1:0]    rew;
    logic [SIT_W-1:0]        nsit;
  } q_item_t;

  typedef struct {
    logic [TQL_MOVE_W-1:0]   chosen;
    logic                    greedy;
    logic [TQL_QW-1:0]       value;
    logic                    sat;
  } q_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TQL_IN_W-1:0] s_axis_tdata = '0;
  logic [TQL_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TQL_OUT_W-1:0] m_axis_tdata;
  logic cfg_wr_en = 1'b0;
  logic [TQL_CFG_IW-1:0] cfg_index = '0;
  logic [TQL_RATE_W-1:0] cfg_data = '0;

  tabular_q_learning_engine u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  q_row_t q_mem [int];
  logic [TQL_RATE_W-1:0] lr_q = RST_LEARN_RATE;
  logic [TQL_RATE_W-1:0] disc_q = RST_DISCOUNT;
  logic [TQL_RATE_W-1:0] eps_q = RST_EXPLORE;
  logic signed [TQL_REW_W-1:0] hit_q = RST_HIT_VALUE;
  logic signed [TQL_REW_W-1:0] die_q = RST_DIE_VALUE;
  q_result_t results_due [$];
  int fault_count = 0;

  // stimulus generation state
  stim_t stim_q [$];
  bit [2:0] gen_slots [int];
  int ready_sits [$];
  logic [TQL_RATE_W-1:0] gen_eps = RST_EXPLORE;
  logic [TQL_REW_W-1:0] gen_hit = RST_HIT_VALUE;
  logic [TQL_REW_W-1:0] gen_die = RST_DIE_VALUE;

  bit in_xfer = 1'b0;
  bit out_xfer = 1'b0;
  bit fast_in = 1'b0;
  bit fast_out = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_run = 0;

  function automatic int draw_wait(bit fast);
    return fast ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int sit_at(logic [TQL_IN_W-1:0] d, int k_lo, int p_lo, int y_lo, int x_lo);
    return int'({d[k_lo], d[p_lo +: TQL_POS_W], d[y_lo +: TQL_POS_W], d[x_lo +: TQL_POS_W]});
  endfunction

  function automatic logic [TQL_MOVE_W-1:0] greedy_move(q_row_t row);
    logic [TQL_MOVE_W-1:0] b;
    b = SLOT0;
    if ($signed(row[SLOT1]) > $signed(row[SLOT0])) b = SLOT1;
    if ($signed(row[MOVE_LAST]) > $signed(row[b])) b = MOVE_LAST;
    return b;
  endfunction

  task automatic q_engine_step(input action_t act, input logic [TQL_IN_W-1:0] d);
    int cur, nxt;
    logic [TQL_MOVE_W-1:0] mv;
    longint opv, rew, old, mx, lrl, total, v;
    q_row_t row, nrow;
    q_result_t r;
    cur = sit_at(d, IN_KIND_LO, IN_PX_LO, IN_BY_LO, IN_BX_LO);
    nxt = sit_at(d, IN_NKIND_LO, IN_NPX_LO, IN_NBY_LO, IN_NBX_LO);
    mv = d[IN_MOVE_LO +: TQL_MOVE_W];
    if (mv > MOVE_LAST) mv = MOVE_LAST;
    opv = longint'($signed(d[IN_OPV_LO +: TQL_QW]));
    rew = longint'($signed(d[IN_REW_LO +: TQL_REW_W]));
    r.chosen = '0;
    r.greedy = 1'b0;
    r.value = '0;
    r.sat = 1'b0;
    row = q_mem.exists(cur) ? q_mem[cur] : '0;
    case (act)
      ACT_CHOOSE: begin
        if (opv > longint'(eps_q)) begin
          r.chosen = greedy_move(row);
          r.greedy = 1'b1;
        end else begin
          r.chosen = mv;
        end
      end
      ACT_LEARN: begin
        nrow = q_mem.exists(nxt) ? q_mem[nxt] : '0;
        mx = longint'($signed(nrow[greedy_move(nrow)]));
        old = longint'($signed(row[mv]));
        if (rew == longint'(hit_q) || rew == longint'(die_q)) begin
          v = rew * 1024;
        end else begin
          lrl = longint'(lr_q);
          total = (65536 - lrl) * old * 65536
                + lrl * (rew * 67108864 + longint'(disc_q) * mx);
          v = (total + (longint'(1) << 31)) >>> 32;
          if (v > Q_TOP) begin
            v = Q_TOP;
            r.sat = 1'b1;
          end
          if (v < Q_BOT) begin
            v = Q_BOT;
            r.sat = 1'b1;
          end
        end
        row[mv] = v[TQL_QW-1:0];
        q_mem[cur] = row;
        r.value = v[TQL_QW-1:0];
      end
      ACT_LOAD: begin
        row[mv] = d[IN_OPV_LO +: TQL_QW];
        q_mem[cur] = row;
        r.value = d[IN_OPV_LO +: TQL_QW];
      end
      default: ;
    endcase
    results_due.insert(results_due.size(), r);
  endtask

  task automatic match(input string name, input logic signed [63:0] want,
                       input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  function automatic q_item_t make_item(action_t act, logic [SIT_W-1:0] sit,
                                        logic [TQL_MOVE_W-1:0] mv, logic [TQL_QW-1:0] opv,
                                        logic [TQL_REW_W-1:0] rew, logic [SIT_W-1:0] nsit);
    q_item_t it;
    it.act = act;
    it.sit = sit;
    it.mv = mv;
    it.opv = opv;
    it.rew = rew;
    it.nsit = nsit;
    return it;
  endfunction

  function automatic logic [TQL_IN_W-1:0] pack_item(q_item_t it);
    logic [TQL_IN_W-1:0] d;
    d = '0;
    {d[IN_KIND_LO], d[IN_PX_LO +: TQL_POS_W], d[IN_BY_LO +: TQL_POS_W],
     d[IN_BX_LO +: TQL_POS_W]} = it.sit;
    {d[IN_NKIND_LO], d[IN_NPX_LO +: TQL_POS_W], d[IN_NBY_LO +: TQL_POS_W],
     d[IN_NBX_LO +: TQL_POS_W]} = it.nsit;
    d[IN_MOVE_LO +: TQL_MOVE_W] = it.mv;
    d[IN_OPV_LO +: TQL_QW] = it.opv;
    d[IN_REW_LO +: TQL_REW_W] = it.rew;
    return d;
  endfunction

  task automatic queue_item(input q_item_t it);
    stim_t s;
    logic [TQL_MOVE_W-1:0] slot;
    bit [2:0] m;
    int key;
    s.kind = EV_ITEM;
    s.act = it.act;
    s.data = pack_item(it);
    s.reg_idx = '0;
    s.reg_val = '0;
    stim_q.insert(stim_q.size(), s);
    if (it.act == ACT_LOAD) begin
      slot = (it.mv > MOVE_LAST) ? MOVE_LAST : it.mv;
      key = int'(it.sit);
      m = gen_slots.exists(key) ? gen_slots[key] : 3'b000;
      if (m != 3'b111) begin
        m[slot] = 1'b1;
        if (m == 3'b111) ready_sits.insert(ready_sits.size(), key);
      end
      gen_slots[key] = m;
    end
  endtask

  task automatic queue_cfg(input logic [TQL_CFG_IW-1:0] idx, input logic [TQL_RATE_W-1:0] val);
    stim_t s;
    s.kind = EV_CFG;
    s.act = ACT_NONE;
    s.data = '0;
    s.reg_idx = idx;
    s.reg_val = val;
    stim_q.insert(stim_q.size(), s);
    if (idx == CFG_EXPLORE) gen_eps = val;
    if (idx == CFG_HIT_VALUE) gen_hit = val[TQL_REW_W-1:0];
    if (idx == CFG_DIE_VALUE) gen_die = val[TQL_REW_W-1:0];
  endtask

  task automatic queue_drain();
    stim_t s;
    s.kind = EV_DRAIN;
    s.act = ACT_NONE;
    s.data = '0;
    s.reg_idx = '0;
    s.reg_val = '0;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic queue_settings(input logic [TQL_RATE_W-1:0] lr, input logic [TQL_RATE_W-1:0] dc,
                                input logic [TQL_RATE_W-1:0] eps,
                                input logic [TQL_REW_W-1:0] hit, input logic [TQL_REW_W-1:0] die);
    queue_cfg(CFG_LEARN_RATE, lr);
    queue_cfg(CFG_DISCOUNT, dc);
    queue_cfg(CFG_EXPLORE, eps);
    queue_cfg(CFG_HIT_VALUE, {6'($urandom), hit});
    queue_cfg(CFG_DIE_VALUE, {6'($urandom), die});
  endtask

  function automatic logic [SIT_W-1:0] rand_sit();
    return SIT_W'($urandom);
  endfunction

  function automatic logic [SIT_W-1:0] pick_ready();
    return SIT_W'(ready_sits[$urandom_range(0, ready_sits.size() - 1)]);
  endfunction

  function automatic logic [TQL_QW-1:0] rand_q();
    case ($urandom_range(0, 3))
      0: return Q_HI_BITS;
      1: return Q_LO_BITS;
      default: return TQL_QW'($urandom);
    endcase
  endfunction

  function automatic logic [TQL_QW-1:0] rand_fraction();
    case ($urandom_range(0, 9))
      0: return {1'b1, 19'($urandom)};
      1: return TQL_QW'($urandom_range(65536, 524287));
      2, 3: return {4'b0000, gen_eps} + TQL_QW'($urandom_range(0, 2)) - 20'd1;
      default: return TQL_QW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [TQL_REW_W-1:0] rand_reward();
    case ($urandom_range(0, 3))
      0: return gen_hit;
      1: return gen_die;
      default: return TQL_REW_W'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin : drive_items
    logic v, we;
    stim_t s;
    v = s_axis_tvalid;
    we = 1'b0;
    if (!rst) begin
      if (in_xfer) v = 1'b0;
      if (!v && stim_q.size() != 0) begin
        if (stim_q[0].kind == EV_ITEM) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            s = stim_q.pop_front();
            s_axis_tdata <= s.data;
            s_axis_tuser <= s.act;
            v = 1'b1;
            if ($urandom_range(0, 31) == 0) fast_in = !fast_in;
            gap_left = draw_wait(fast_in);
            idle_run = 0;
          end
        end else if (results_due.size() != 0) begin
          idle_run = 0;
        end else if (idle_run < SETTLE) begin
          idle_run++;
        end else begin
          s = stim_q.pop_front();
          if (s.kind == EV_CFG) begin
            we = 1'b1;
            cfg_index <= s.reg_idx;
            cfg_data <= s.reg_val;
          end
        end
      end
    end
    s_axis_tvalid <= v;
    cfg_wr_en <= we;
  end

  always @(negedge clk) begin : drive_ready
    if (out_xfer) begin
      if ($urandom_range(0, 31) == 0) fast_out = !fast_out;
      stall_left = draw_wait(fast_out);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    q_result_t want;
    logic [TQL_OUT_W-1:0] got;
    in_xfer = 1'b0;
    out_xfer = 1'b0;
    if (!rst) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LEARN_RATE: lr_q = cfg_data;
          CFG_DISCOUNT:   disc_q = cfg_data;
          CFG_EXPLORE:    eps_q = cfg_data;
          CFG_HIT_VALUE:  hit_q = cfg_data[TQL_REW_W-1:0];
          CFG_DIE_VALUE:  die_q = cfg_data[TQL_REW_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_xfer = 1'b1;
        got = m_axis_tdata;
        if (results_due.size() == 0) begin
          $error("m_axis transfer with no result due: tdata %h", got);
          fault_count++;
        end else begin
          want = results_due.pop_front();
          match("chosen_move", want.chosen, got[OUT_MOVE_LO +: TQL_MOVE_W]);
          match("was_greedy", want.greedy, got[OUT_GREEDY_LO]);
          match("result_value", $signed(want.value), $signed(got[OUT_VAL_LO +: TQL_QW]));
          match("saturated", want.sat, got[OUT_SAT_LO]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_xfer = 1'b1;
        q_engine_step(action_t'(s_axis_tuser), s_axis_tdata);
      end
    end
  end

  initial begin : stimulus
    q_item_t it;
    int p, base;
    logic [SIT_W-1:0] sit;

    queue_item(make_item(ACT_LOAD, SIT_A, SLOT0, Q_LO_BITS, REW_TOP, SIT_B));
    queue_item(make_item(ACT_LOAD, SIT_A, SLOT1, Q_HI_BITS, REW_BOT, SIT_B));
    queue_item(make_item(ACT_LOAD, SIT_A, MOVE_LAST, Q_HI_BITS, REW_TOP, SIT_A));
    queue_item(make_item(ACT_LOAD, SIT_B, SLOT0, 20'd7, REW_BOT, SIT_A));
    queue_item(make_item(ACT_LOAD, SIT_B, SLOT1, 20'd7, REW_TOP, SIT_B));
    queue_item(make_item(ACT_LOAD, SIT_B, SLOT_ALIAS, 20'd7, REW_BOT, SIT_B));
    queue_item(make_item(ACT_CHOOSE, SIT_A, SLOT_ALIAS, 20'd65535, REW_TOP, SIT_B));
    queue_item(make_item(ACT_CHOOSE, SIT_A, SLOT0, 20'd65536, REW_BOT, SIT_B));
    queue_item(make_item(ACT_CHOOSE, SIT_B, SLOT1, Q_HI_BITS, REW_TOP, SIT_A));
    queue_item(make_item(ACT_CHOOSE, SIT_B, SLOT1, Q_LO_BITS, REW_BOT, SIT_A));
    queue_item(make_item(ACT_LEARN, SIT_A, SLOT1, Q_LO_BITS, REW_TOP, SIT_A));
    queue_item(make_item(ACT_LEARN, SIT_B, SLOT0, Q_HI_BITS, REW_BOT, SIT_A));
    queue_item(make_item(ACT_LEARN, SIT_B, SLOT1, '0, RST_HIT_VALUE, SIT_B));
    queue_item(make_item(ACT_LEARN, SIT_B, SLOT_ALIAS, '1, RST_DIE_VALUE, SIT_A));
    queue_item(make_item(ACT_NONE, SIT_A, SLOT_ALIAS, '1, '1, SIT_B));
    queue_item(make_item(ACT_CHOOSE, SIT_B, MOVE_LAST, 20'd65536, '0, SIT_A));

    for (int n = 0; n < 24; n++) begin
      sit = rand_sit();
      base = $urandom_range(0, TQL_MOVES - 1);
      for (int j = 0; j < TQL_MOVES; j++) begin
        it = make_item(ACT_LOAD, sit, 2'((base + j) % TQL_MOVES), rand_q(),
                       TQL_REW_W'($urandom), rand_sit());
        if (it.mv == MOVE_LAST && $urandom_range(0, 1) == 1) it.mv = SLOT_ALIAS;
        queue_item(it);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      queue_drain();
      case (ph)
        0: ;
        1: begin
          queue_settings('1, '1, '0, REW_TOP, REW_BOT);
          queue_item(make_item(ACT_LOAD, SIT_C, SLOT0, Q_LO_BITS, '0, SIT_C));
          queue_item(make_item(ACT_LOAD, SIT_C, SLOT1, Q_LO_BITS, '0, SIT_C));
          queue_item(make_item(ACT_LOAD, SIT_C, MOVE_LAST, Q_LO_BITS, '0, SIT_C));
          queue_item(make_item(ACT_LEARN, SIT_C, SLOT0, '0, 10'h201, SIT_C));
        end
        2: queue_settings('0, '0, '1, REW_BOT, REW_TOP);
        default: queue_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                TQL_REW_W'($urandom), TQL_REW_W'($urandom));
      endcase
      for (int n = 0; n < 250; n++) begin
        it = make_item(ACT_NONE, rand_sit(), TQL_MOVE_W'($urandom), TQL_QW'($urandom),
                       TQL_REW_W'($urandom), rand_sit());
        p = $urandom_range(0, 99);
        if (p < 8) begin
          it.act = ACT_LOAD;
          it.opv = rand_q();
        end else if (p < 20) begin
          it.act = ACT_LOAD;
          it.sit = pick_ready();
          it.opv = rand_q();
        end else if (p < 50) begin
          it.act = ACT_CHOOSE;
          it.sit = pick_ready();
          it.opv = rand_fraction();
        end else if (p < 96) begin
          it.act = ACT_LEARN;
          it.sit = pick_ready();
          it.nsit = ($urandom_range(0, 7) == 0) ? it.sit : pick_ready();
          it.rew = rand_reward();
        end else begin
          it.sit = pick_ready();
        end
        queue_item(it);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || s_axis_tvalid || results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
